### hdl/sswr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswr_pkg
// shared constants for the worklist shortest path unit
// ----------------------------------------------------------------------------
package sswr_pkg;

  localparam int unsigned NODES = 1024;
  localparam int unsigned EDGES = 4096;
  localparam int unsigned NW    = $clog2(NODES);
  localparam int unsigned EAW   = $clog2(EDGES);
  localparam int unsigned ECW   = $clog2(EDGES + 1);
  localparam int unsigned DW    = 32;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_RUN   = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_ORDER = 2'd2;

endpackage

### hdl/sswr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sswr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sssp_worklist_relaxation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_worklist_relaxation_unit
// graph edge store with a fifo worklist that relaxes shortest distances
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// in       input      in_valid_i/in_stall_o  func_i node_a_i node_b_i weight_i
// out      output     out_valid_o/out_stall_i distance_o reached_o status_o
//
// add edge: handled in idle; read: waits in a read-wait state for the registered distance ram read
// clear: sweeps every entry of the per-node edge range ram
// run: distance sweep and a seed state, then pop, getn, getr and edge states per
//   popped node plus edge, eread and cmp states per relaxed edge and one final pop
//   state, all through the single distance ram
// after reset a sweep initializes node rams; input is stalled
// input is stalled while busy or while a result waits on the output
// ----------------------------------------------------------------------------
module sssp_worklist_relaxation_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [9:0]  node_a_i,
  input  logic [9:0]  node_b_i,
  input  logic [31:0] weight_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] distance_o,
  output logic        reached_o,
  output logic [1:0]  status_o
);

  localparam int unsigned NW  = sswr_pkg::NW;
  localparam int unsigned EAW = sswr_pkg::EAW;
  localparam int unsigned ECW = sswr_pkg::ECW;
  localparam int unsigned DW  = sswr_pkg::DW;
  localparam int unsigned RW  = EAW + ECW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SWEEP  = 4'd1;
  localparam logic [3:0] S_SEED   = 4'd2;
  localparam logic [3:0] S_RDWAIT = 4'd3;
  localparam logic [3:0] S_POP    = 4'd4;
  localparam logic [3:0] S_GETN   = 4'd5;
  localparam logic [3:0] S_GETR   = 4'd6;
  localparam logic [3:0] S_EDGE   = 4'd7;
  localparam logic [3:0] S_EREAD  = 4'd8;
  localparam logic [3:0] S_CMP    = 4'd9;

  localparam logic [DW-1:0] UNREACHED = '1;

  logic [3:0]     state_q, state_d;
  logic [NW-1:0]  sweep_q, sweep_d;
  logic           sw_dist_q, sw_dist_d;
  logic           sw_range_q, sw_range_d;
  logic           sw_run_q, sw_run_d;
  logic [NW-1:0]  src_q, src_d;
  logic [NW-1:0]  head_q, head_d;
  logic [NW-1:0]  tail_q, tail_d;
  logic [NW:0]    fill_q, fill_d;
  logic [ECW-1:0] stored_q, stored_d;
  logic           prev_none_q, prev_none_d;
  logic [NW-1:0]  prev_q, prev_d;
  logic [EAW-1:0] cur_first_q, cur_first_d;
  logic [ECW-1:0] cur_total_q, cur_total_d;
  logic [DW-1:0]  dn_q, dn_d;
  logic [ECW-1:0] e_q, e_d;
  logic [ECW-1:0] end_q, end_d;
  logic [NW-1:0]  dst_q, dst_d;
  logic [DW-1:0]  sum_q, sum_d;
  logic           out_valid_q, out_valid_d;
  logic [DW-1:0]  dist_out_q, dist_out_d;
  logic           reached_q, reached_d;
  logic [1:0]     status_q, status_d;

  logic           dist_we, inq_we, fifo_we, range_we, edge_we;
  logic [NW-1:0]  dist_waddr, dist_raddr, inq_waddr, inq_raddr;
  logic [NW-1:0]  fifo_waddr, fifo_raddr, fifo_wdata, fifo_rdata;
  logic [NW-1:0]  range_waddr, range_raddr;
  logic [DW-1:0]  dist_wdata, dist_rdata;
  logic           inq_wdata, inq_rdata;
  logic [RW-1:0]  range_wdata, range_rdata;
  logic [EAW-1:0] edge_waddr, edge_raddr;
  logic [NW+DW-1:0] edge_wdata, edge_rdata;

  logic           accept;
  logic           new_node;
  logic [DW:0]    sum_wide;
  logic           lower;
  logic           push;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  assign new_node   = prev_none_q || (node_a_i != prev_q);
  assign sum_wide   = {1'b0, dn_q} + {1'b0, edge_rdata[DW-1:0]};
  assign lower      = sum_q < dist_rdata;
  assign push       = lower && !inq_rdata && (fill_q < (NW+1)'(sswr_pkg::NODES));

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    sw_dist_d   = sw_dist_q;
    sw_range_d  = sw_range_q;
    sw_run_d    = sw_run_q;
    src_d       = src_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    stored_d    = stored_q;
    prev_none_d = prev_none_q;
    prev_d      = prev_q;
    cur_first_d = cur_first_q;
    cur_total_d = cur_total_q;
    dn_d        = dn_q;
    e_d         = e_q;
    end_d       = end_q;
    dst_d       = dst_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    dist_out_d  = dist_out_q;
    reached_d   = reached_q;
    status_d    = status_q;

    dist_we     = 1'b0;
    dist_waddr  = sweep_q;
    dist_wdata  = UNREACHED;
    dist_raddr  = node_a_i;
    inq_we      = 1'b0;
    inq_waddr   = sweep_q;
    inq_wdata   = 1'b0;
    inq_raddr   = edge_rdata[NW+DW-1:DW];
    fifo_we     = 1'b0;
    fifo_waddr  = tail_q;
    fifo_wdata  = dst_q;
    fifo_raddr  = head_q;
    range_we    = 1'b0;
    range_waddr = sweep_q;
    range_wdata = '0;
    range_raddr = fifo_rdata;
    edge_we     = 1'b0;
    edge_waddr  = stored_q[EAW-1:0];
    edge_wdata  = {node_b_i, weight_i};
    edge_raddr  = e_q[EAW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          dist_out_d = '0;
          reached_d  = 1'b0;
          status_d   = sswr_pkg::STATUS_OK;
          unique case (func_i)
            sswr_pkg::FUNC_CLEAR: begin
              out_valid_d = 1'b1;
              stored_d    = '0;
              prev_none_d = 1'b1;
              sweep_d     = '0;
              sw_dist_d   = 1'b0;
              sw_range_d  = 1'b1;
              sw_run_d    = 1'b0;
              state_d     = S_SWEEP;
            end
            sswr_pkg::FUNC_ADD: begin
              out_valid_d = 1'b1;
              if (stored_q >= ECW'(sswr_pkg::EDGES)) begin
                status_d = sswr_pkg::STATUS_FULL;
              end else if (!prev_none_q && (node_a_i < prev_q)) begin
                status_d = sswr_pkg::STATUS_ORDER;
              end else begin
                cur_first_d = new_node ? stored_q[EAW-1:0] : cur_first_q;
                cur_total_d = new_node ? ECW'(1) : cur_total_q + ECW'(1);
                range_we    = 1'b1;
                range_waddr = node_a_i;
                range_wdata = {cur_first_d, cur_total_d};
                edge_we     = 1'b1;
                stored_d    = stored_q + ECW'(1);
                prev_d      = node_a_i;
                prev_none_d = 1'b0;
              end
            end
            sswr_pkg::FUNC_RUN: begin
              src_d      = node_a_i;
              sweep_d    = '0;
              sw_dist_d  = 1'b1;
              sw_range_d = 1'b0;
              sw_run_d   = 1'b1;
              state_d    = S_SWEEP;
            end
            sswr_pkg::FUNC_READ: begin
              state_d = S_RDWAIT;
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        dist_we  = sw_dist_q;
        inq_we   = sw_dist_q;
        range_we = sw_range_q;
        sweep_d  = sweep_q + NW'(1);
        if (sweep_q == NW'(sswr_pkg::NODES - 1)) begin
          state_d = sw_run_q ? S_SEED : S_IDLE;
        end
      end
      S_SEED: begin
        dist_we    = 1'b1;
        dist_waddr = src_q;
        dist_wdata = '0;
        inq_we     = 1'b1;
        inq_waddr  = src_q;
        inq_wdata  = 1'b1;
        fifo_we    = 1'b1;
        fifo_waddr = '0;
        fifo_wdata = src_q;
        head_d     = '0;
        tail_d     = NW'(1);
        fill_d     = (NW+1)'(1);
        state_d    = S_POP;
      end
      S_RDWAIT: begin
        out_valid_d = 1'b1;
        dist_out_d  = dist_rdata;
        reached_d   = dist_rdata != UNREACHED;
        status_d    = sswr_pkg::STATUS_OK;
        state_d     = S_IDLE;
      end
      S_POP: begin
        if (fill_q == '0) begin
          out_valid_d = 1'b1;
          dist_out_d  = '0;
          reached_d   = 1'b0;
          status_d    = sswr_pkg::STATUS_OK;
          state_d     = S_IDLE;
        end else begin
          head_d  = head_q + NW'(1);
          fill_d  = fill_q - (NW+1)'(1);
          state_d = S_GETN;
        end
      end
      S_GETN: begin
        dist_raddr = fifo_rdata;
        inq_we     = 1'b1;
        inq_waddr  = fifo_rdata;
        inq_wdata  = 1'b0;
        state_d    = S_GETR;
      end
      S_GETR: begin
        dn_d    = dist_rdata;
        e_d     = ECW'(range_rdata[RW-1:ECW]);
        end_d   = ECW'(range_rdata[RW-1:ECW]) + range_rdata[ECW-1:0];
        state_d = S_EDGE;
      end
      S_EDGE: begin
        if ((e_q < end_q) && (e_q < ECW'(sswr_pkg::EDGES))) begin
          state_d = S_EREAD;
        end else begin
          state_d = S_POP;
        end
      end
      S_EREAD: begin
        dist_raddr = edge_rdata[NW+DW-1:DW];
        dst_d      = edge_rdata[NW+DW-1:DW];
        sum_d      = sum_wide[DW] ? UNREACHED : sum_wide[DW-1:0];
        state_d    = S_CMP;
      end
      S_CMP: begin
        if (lower) begin
          dist_we    = 1'b1;
          dist_waddr = dst_q;
          dist_wdata = sum_q;
        end
        if (push) begin
          inq_we    = 1'b1;
          inq_waddr = dst_q;
          inq_wdata = 1'b1;
          fifo_we   = 1'b1;
          tail_d    = tail_q + NW'(1);
          fill_d    = fill_q + (NW+1)'(1);
        end
        e_d     = e_q + ECW'(1);
        state_d = S_EDGE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      sw_dist_q   <= 1'b1;
      sw_range_q  <= 1'b1;
      sw_run_q    <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      stored_q    <= '0;
      prev_none_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      sw_dist_q   <= sw_dist_d;
      sw_range_q  <= sw_range_d;
      sw_run_q    <= sw_run_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      stored_q    <= stored_d;
      prev_none_q <= prev_none_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    prev_q      <= prev_d;
    cur_first_q <= cur_first_d;
    cur_total_q <= cur_total_d;
    dn_q        <= dn_d;
    e_q         <= e_d;
    end_q       <= end_d;
    dst_q       <= dst_d;
    sum_q       <= sum_d;
    dist_out_q  <= dist_out_d;
    reached_q   <= reached_d;
    status_q    <= status_d;
  end

  sswr_ram #(.WIDTH(DW), .DEPTH(sswr_pkg::NODES)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  sswr_ram #(.WIDTH(1), .DEPTH(sswr_pkg::NODES)) u_inq_ram (
    .clk_i   (clk_i),
    .we_i    (inq_we),
    .waddr_i (inq_waddr),
    .wdata_i (inq_wdata),
    .raddr_i (inq_raddr),
    .rdata_o (inq_rdata)
  );

  sswr_ram #(.WIDTH(NW), .DEPTH(sswr_pkg::NODES)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  sswr_ram #(.WIDTH(RW), .DEPTH(sswr_pkg::NODES)) u_range_ram (
    .clk_i   (clk_i),
    .we_i    (range_we),
    .waddr_i (range_waddr),
    .wdata_i (range_wdata),
    .raddr_i (range_raddr),
    .rdata_o (range_rdata)
  );

  sswr_ram #(.WIDTH(NW + DW), .DEPTH(sswr_pkg::EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_out_q;
  assign reached_o   = reached_q;
  assign status_o    = status_q;

endmodule
